/* rtl/fca_pkg.sv */
// Package with the shared constants, codes and control types of the chain allocator.
`timescale 1ns / 1ps
package fca_pkg;
  localparam int SECTORS = 1024;
  localparam int AW = 10;
  localparam int CW = 11;
  localparam int LW = 11;
  localparam logic [LW-1:0] END_LINK = 11'h7FF;

  localparam logic [2:0] OP_INIT = 3'd0;
  localparam logic [2:0] OP_ALLOC = 3'd1;
  localparam logic [2:0] OP_NEXT = 3'd2;
  localparam logic [2:0] OP_SET = 3'd3;
  localparam logic [2:0] OP_FREE = 3'd4;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NOSPACE = 2'd1;
  localparam logic [1:0] ST_BUSY = 2'd2;

  typedef enum logic [2:0] {
    S_CLEAR_RST, S_CLEAR_INIT, S_IDLE, S_EXEC, S_SCAN, S_SCHK, S_ENDW, S_FIN
  } state_t;

  typedef struct packed {
    logic in_ready;
    logic item_load;
    logic clr_begin;
    logic clr_step;
    logic clr_end;
    logic alloc_start;
    logic scan_take;
    logic scan_inc;
    logic end_link;
    logic set_do;
    logic free_do;
    logic next_cap;
    logic status_we;
    logic [1:0] status_val;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic in_valid;
    logic [2:0] op;
    logic busy_rd;
    logic count_zero;
    logic count_one;
    logic count_gt_free;
    logic left_two;
    logic scan_last;
    logic clr_last;
    logic out_full;
  } stat_t;
endpackage

/* rtl/fca_if.sv */
// Channel interfaces for the operation words and the result words.
`timescale 1ns / 1ps
interface fca_in_if;
  import fca_pkg::*;
  logic valid;
  logic ready;
  logic [2:0] op;
  logic [AW-1:0] sector_index;
  logic [CW-1:0] sector_count;
  logic signed [LW-1:0] link_value;
  modport source(output valid, op, sector_index, sector_count, link_value, input ready);
  modport sink(input valid, op, sector_index, sector_count, link_value, output ready);
endinterface

interface fca_out_if;
  import fca_pkg::*;
  logic valid;
  logic ready;
  logic [1:0] status;
  logic signed [LW-1:0] link_out;
  logic [CW-1:0] free_sectors;
  modport source(output valid, status, link_out, free_sectors, input ready);
  modport sink(input valid, status, link_out, free_sectors, output ready);
endinterface

/* rtl/fca_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module fca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* rtl/fca_ctrl.sv */
// Controller state machine that sequences every operation of the allocator.
`timescale 1ns / 1ps
module fca_ctrl import fca_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  stat_t st,
  output cmd_t  cmd
);
  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR_RST;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd = '0;
    state_next = state;
    unique case (state)
      S_CLEAR_RST, S_CLEAR_INIT: begin
        cmd.clr_step = 1'b1;
        if (st.clr_last) begin
          cmd.clr_end = 1'b1;
          state_next = (state == S_CLEAR_INIT) ? S_FIN : S_IDLE;
        end
      end
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        if (st.in_valid) begin
          cmd.item_load = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = S_FIN;
        unique case (st.op)
          OP_INIT: begin
            cmd.clr_begin = 1'b1;
            state_next = S_CLEAR_INIT;
          end
          OP_ALLOC: begin
            priority if (st.busy_rd) begin
              cmd.status_we = 1'b1;
              cmd.status_val = ST_BUSY;
            end else if (st.count_gt_free) begin
              cmd.status_we = 1'b1;
              cmd.status_val = ST_NOSPACE;
            end else if (!st.count_zero) begin
              cmd.alloc_start = 1'b1;
              if (st.count_one) begin
                cmd.end_link = 1'b1;
              end else begin
                state_next = S_SCAN;
              end
            end
          end
          OP_NEXT: cmd.next_cap = 1'b1;
          OP_SET: cmd.set_do = 1'b1;
          OP_FREE: cmd.free_do = 1'b1;
          default: ;
        endcase
      end
      S_SCAN: state_next = S_SCHK;
      S_SCHK: begin
        if (!st.busy_rd) begin
          cmd.scan_take = 1'b1;
          cmd.scan_inc = 1'b1;
          state_next = (st.left_two || st.scan_last) ? S_ENDW : S_SCAN;
        end else if (st.scan_last) begin
          state_next = S_ENDW;
        end else begin
          cmd.scan_inc = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_ENDW: begin
        cmd.end_link = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        if (!st.out_full) begin
          cmd.out_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule

/* rtl/fca_dp.sv */
// Datapath with the busy bitmap, the link table, the free count and the result register.
`timescale 1ns / 1ps
module fca_dp import fca_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic [CW-1:0] reserved_sectors,
  fca_in_if.sink   item_in,
  fca_out_if.source result_out,
  input  cmd_t  cmd,
  output stat_t st
);
  logic [2:0]    op;
  logic [AW-1:0] idx;
  logic [CW-1:0] count;
  logic [LW-1:0] value;
  logic [AW-1:0] cur;
  logic [AW-1:0] scan;
  logic [CW-1:0] left;
  logic [AW-1:0] ptr;
  logic [CW-1:0] rsv;
  logic [CW-1:0] free_total;
  logic [1:0]    status_r;
  logic [LW-1:0] link_r;
  logic          out_valid;
  logic [1:0]    out_status;
  logic [LW-1:0] out_link;
  logic [CW-1:0] out_free;

  logic          busy_we, busy_wdata, busy_rdata;
  logic [AW-1:0] busy_waddr, busy_raddr;
  logic          link_we;
  logic [AW-1:0] link_waddr, link_raddr;
  logic [LW-1:0] link_wdata, link_rdata;
  logic          free_dec;
  logic [CW-1:0] rsv_clip;

  fca_ram #(.WIDTH(1), .DEPTH(SECTORS)) u_busy (
    .clk(clk), .we(busy_we), .waddr(busy_waddr), .wdata(busy_wdata),
    .raddr(busy_raddr), .rdata(busy_rdata)
  );

  fca_ram #(.WIDTH(LW), .DEPTH(SECTORS)) u_link (
    .clk(clk), .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
    .raddr(link_raddr), .rdata(link_rdata)
  );

  assign busy_raddr = cmd.in_ready ? item_in.sector_index : scan;
  assign link_raddr = cmd.in_ready ? item_in.sector_index : idx;
  assign rsv_clip = (rsv > CW'(SECTORS)) ? CW'(SECTORS) : rsv;

  always_comb begin
    busy_we = 1'b0;
    busy_waddr = idx;
    busy_wdata = 1'b1;
    priority if (cmd.clr_step) begin
      busy_we = 1'b1;
      busy_waddr = ptr;
      busy_wdata = ({1'b0, ptr} < rsv);
    end else if (cmd.alloc_start) begin
      busy_we = 1'b1;
      busy_waddr = cur;
    end else if (cmd.scan_take) begin
      busy_we = 1'b1;
      busy_waddr = scan;
    end else if (cmd.set_do && !busy_rdata) begin
      busy_we = 1'b1;
    end
  end

  always_comb begin
    link_we = 1'b1;
    link_waddr = idx;
    link_wdata = END_LINK;
    priority if (cmd.clr_step) begin
      link_waddr = ptr;
    end else if (cmd.end_link) begin
      link_waddr = cur;
    end else if (cmd.scan_take) begin
      link_waddr = cur;
      link_wdata = LW'(scan);
    end else if (cmd.set_do) begin
      link_wdata = value;
    end else if (!cmd.free_do) begin
      link_we = 1'b0;
    end
  end

  assign free_dec = cmd.alloc_start || cmd.scan_take || (cmd.set_do && !busy_rdata);

  always_ff @(posedge clk) begin
    if (rst) begin
      rsv <= CW'(1);
      ptr <= '0;
      free_total <= CW'(SECTORS - 1);
      out_valid <= 1'b0;
    end else begin
      if (cmd.clr_begin) begin
        rsv <= reserved_sectors;
        ptr <= '0;
      end else if (cmd.clr_step) begin
        ptr <= ptr + AW'(1);
      end
      if (cmd.clr_end) begin
        free_total <= CW'(SECTORS) - rsv_clip;
      end else if (free_dec && free_total != '0) begin
        free_total <= free_total - CW'(1);
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (result_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.item_load) begin
      op <= item_in.op;
      idx <= item_in.sector_index;
      cur <= item_in.sector_index;
      count <= item_in.sector_count;
      value <= item_in.link_value;
      scan <= '0;
      status_r <= ST_OK;
      link_r <= END_LINK;
    end else begin
      if (cmd.status_we) begin
        status_r <= cmd.status_val;
      end
      if (cmd.next_cap) begin
        link_r <= link_rdata;
      end
      if (cmd.scan_take) begin
        cur <= scan;
      end
      if (cmd.scan_inc) begin
        scan <= scan + AW'(1);
      end
    end
    if (cmd.alloc_start) begin
      left <= count;
    end else if (cmd.scan_take) begin
      left <= left - CW'(1);
    end
    if (cmd.out_load) begin
      out_status <= status_r;
      out_link <= link_r;
      out_free <= free_total;
    end
  end

  assign item_in.ready = cmd.in_ready;
  assign result_out.valid = out_valid;
  assign result_out.status = out_status;
  assign result_out.link_out = out_link;
  assign result_out.free_sectors = out_free;

  assign st.in_valid = item_in.valid;
  assign st.op = op;
  assign st.busy_rd = busy_rdata;
  assign st.count_zero = (count == '0);
  assign st.count_one = (count == CW'(1));
  assign st.count_gt_free = (count > free_total);
  assign st.left_two = (left == CW'(2));
  assign st.scan_last = (scan == AW'(SECTORS - 1));
  assign st.clr_last = (ptr == AW'(SECTORS - 1));
  assign st.out_full = out_valid && !result_out.ready;

  a_free_bound: assert property (@(posedge clk) disable iff (rst)
    free_total <= CW'(SECTORS)) else $error("Free count exceeds the sector total.");
  a_take_free: assert property (@(posedge clk) disable iff (rst)
    cmd.scan_take |-> !busy_rdata) else $error("Chain took a busy sector.");
  a_out_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !out_valid || result_out.ready) else $error("Result overwritten.");
  a_clr_count: assert property (@(posedge clk) disable iff (rst)
    cmd.clr_end |=> free_total == CW'(SECTORS) - $past(rsv_clip))
    else $error("Free count wrong after rebuild.");
endmodule

/* rtl/fat_chain_allocator.sv */
// Top level of the sector chain allocator: APB register, controller and datapath.
//
// Operation words arrive on item_in (valid/ready); each yields exactly one result
// word on result_out. Operations: init, allocate, read next link, set link, free.
// The APB port holds reserved_sectors at byte address 0; it is used by the next init.
// One word is worked on at a time. Next, set and free pass through the EXEC and FIN states
// before the next word is taken, and the result word is registered in FIN; a rejected
// or empty allocate takes the same path. An allocate probes the busy bitmap with a single
// RAM read port, passing through a SCAN and a SCHK state for each probed sector.
// Init rewrites both tables one sector a cycle.
// After reset the block runs a clearing pass over every sector and holds ready low; APB
// writes are taken during it. Results sit in an output register. If the receiver
// stalls, the next word is still taken and worked on, and its finished result waits
// in the result registers, with ready low, until the output register is free.
`timescale 1ns / 1ps
module fat_chain_allocator import fca_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  fca_in_if.sink      item_in,
  fca_out_if.source   result_out,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  logic [CW-1:0] reserved_sectors;
  cmd_t cmd;
  stat_t st;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      reserved_sectors <= CW'(1);
    end else if (psel && penable && pwrite && paddr[2] == 1'b0) begin
      reserved_sectors <= pwdata[CW-1:0];
    end
  end

  assign prdata = (paddr[2] == 1'b0) ? {21'd0, reserved_sectors} : 32'd0;

  fca_ctrl u_ctrl (.clk(clk), .rst(rst), .st(st), .cmd(cmd));

  fca_dp u_dp (
    .clk(clk), .rst(rst), .reserved_sectors(reserved_sectors),
    .item_in(item_in), .result_out(result_out), .cmd(cmd), .st(st)
  );
endmodule
